@@ design/hls_pkg.sv @@
// Package for the hex literal scanner: widths, scan phase codes, result type
// and the hex digit decoder. No dependencies; used by every file in design/.
`timescale 1ns / 1ps

package hls_pkg;

	// Width of the accumulated value (8 to 64, a multiple of 4 is expected).
	localparam int VALUE_WIDTH = 64;
	localparam int OUT_WIDTH   = 64;
	localparam int COUNT_WIDTH = 8;

	// Scan phase codes.
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_ZERO   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;

	// Characters that matter to the prefix.
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_X_LOWER = 8'h78;
	localparam logic [7:0] CH_X_UPPER = 8'h58;

	// One result item as it travels from the scanner core to the output queue.
	typedef struct packed {
		logic [OUT_WIDTH-1:0]   literal_value;
		logic [COUNT_WIDTH-1:0] digit_count;
		logic                   upper_prefix;
		logic                   overflow;
	} hls_result_t;

	// Decoded character: a hex digit flag and its nibble value.
	typedef struct packed {
		logic       is_hex;
		logic [3:0] nibble;
	} hls_digit_t;

	function automatic hls_digit_t hex_decode(input logic [7:0] c);
		hls_digit_t d;
		d.is_hex = 1'b0;
		d.nibble = 4'd0;
		case (c) inside
			[8'h30:8'h39]: begin
				d.is_hex = 1'b1;
				d.nibble = c[3:0];
			end
			[8'h41:8'h46], [8'h61:8'h66]: begin
				d.is_hex = 1'b1;
				d.nibble = 4'(c[2:0] + 4'd9);
			end
			default: begin
				d.is_hex = 1'b0;
			end
		endcase
		return d;
	endfunction

endpackage

@@ design/hls_if.sv @@
// Channel interfaces of the hex literal scanner: byte input and result output.
// Depends on hls_pkg for the field widths.
`timescale 1ns / 1ps

interface hls_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_stream;

	modport source (output valid, output char_in, output end_of_stream, input ready);
	modport sink   (input valid, input char_in, input end_of_stream, output ready);
endinterface

interface hls_out_if;
	logic                            valid;
	logic                            ready;
	logic [hls_pkg::OUT_WIDTH-1:0]   literal_value;
	logic [hls_pkg::COUNT_WIDTH-1:0] digit_count;
	logic                            upper_prefix;
	logic                            overflow;

	modport source (output valid, output literal_value, output digit_count,
		output upper_prefix, output overflow, input ready);
	modport sink   (input valid, input literal_value, input digit_count,
		input upper_prefix, input overflow, output ready);
endinterface

@@ design/hex_literal_scanner.sv @@
// Top level of the hex literal scanner: joins the scanner core to the result
// queue. Depends on hls_pkg, hls_if, hls_core and hls_out_queue.
//
// Usage: bytes of a text stream enter on in_ch, one per accepted item, with
// end_of_stream set on the final byte. Each literal 0x/0X followed by hex
// digits yields one item on out_ch carrying its value (wrapping at the value
// width), its digit count (saturating at 255), the prefix case and a sticky
// overflow flag. A literal ends at the first non-hex byte or at end of stream.
// Timing: a result is written into the queue when the byte that ends the
// literal is accepted; out_ch.valid comes from the registered fill count.
// Throughput: one byte per cycle while the queue has room, set by the single
// register stage of the scan state. Stalls: a two-entry queue holds results;
// in_ch.ready stays high while the queue has a free entry, so input continues
// during an output stall and halts only when both entries are full.
// Reset: arst_n clears the scan state to idle and empties the queue.
`timescale 1ns / 1ps

module hex_literal_scanner (
	input  logic             clk,
	input  logic             arst_n,
	hls_in_if.sink           in_ch,
	hls_out_if.source        out_ch
);

	logic                 accept;
	logic                 emit;
	logic                 has_room;
	hls_pkg::hls_result_t core_result;
	hls_pkg::hls_result_t out_result;

	assign in_ch.ready = has_room;
	assign accept      = in_ch.valid && has_room;

	// Scan state and literal detection.
	hls_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.char_in       (in_ch.char_in),
		.end_of_stream (in_ch.end_of_stream),
		.emit          (emit),
		.result        (core_result)
	);

	// Result buffering toward the receiver.
	hls_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && emit),
		.push_data (core_result),
		.has_room  (has_room),
		.pop_valid (out_ch.valid),
		.pop_ready (out_ch.ready),
		.pop_data  (out_result)
	);

	assign out_ch.literal_value = out_result.literal_value;
	assign out_ch.digit_count   = out_result.digit_count;
	assign out_ch.upper_prefix  = out_result.upper_prefix;
	assign out_ch.overflow      = out_result.overflow;

endmodule

@@ design/hls_core.sv @@
// Scanner core: holds the scan state and, for each accepted byte, works out
// the next state and whether a literal ends. Depends on hls_pkg.
`timescale 1ns / 1ps

module hls_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           char_in,
	input  logic                 end_of_stream,
	output logic                 emit,
	output hls_pkg::hls_result_t result
);

	logic [1:0]                        phase_q, phase_n;
	logic [hls_pkg::VALUE_WIDTH-1:0]   acc_q, acc_n;
	logic [hls_pkg::COUNT_WIDTH-1:0]   cnt_q, cnt_n;
	logic                              upper_q, upper_n;
	logic                              ovf_q, ovf_n;
	hls_pkg::hls_digit_t               dig;
	logic                              is_x;

	assign dig  = hls_pkg::hex_decode(char_in);
	assign is_x = (char_in == hls_pkg::CH_X_LOWER) || (char_in == hls_pkg::CH_X_UPPER);

	// Next state and literal end for the byte at the input.
	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		cnt_n   = cnt_q;
		upper_n = upper_q;
		ovf_n   = ovf_q;
		emit    = 1'b0;
		case (phase_q)
			hls_pkg::PH_DIGITS: begin
				if (!dig.is_hex) begin
					emit    = 1'b1;
					phase_n = hls_pkg::PH_IDLE;
				end else begin
					ovf_n = ovf_q | (|acc_q[hls_pkg::VALUE_WIDTH-1 -: 4]);
					acc_n = {acc_q[hls_pkg::VALUE_WIDTH-5:0], dig.nibble};
					cnt_n = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
					if (end_of_stream) begin
						emit    = 1'b1;
						phase_n = hls_pkg::PH_IDLE;
					end
				end
			end
			hls_pkg::PH_ZERO: begin
				if (is_x) begin
					phase_n = hls_pkg::PH_DIGITS;
					acc_n   = '0;
					cnt_n   = '0;
					upper_n = (char_in == hls_pkg::CH_X_UPPER);
					ovf_n   = 1'b0;
					if (end_of_stream) begin
						emit    = 1'b1;
						phase_n = hls_pkg::PH_IDLE;
					end
				end else begin
					phase_n = (char_in == hls_pkg::CH_ZERO && !end_of_stream) ?
						hls_pkg::PH_ZERO : hls_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_n = (char_in == hls_pkg::CH_ZERO && !end_of_stream) ?
					hls_pkg::PH_ZERO : hls_pkg::PH_IDLE;
			end
		endcase
	end

	// The result always reflects the state after this byte.
	assign result.literal_value = hls_pkg::OUT_WIDTH'(acc_n);
	assign result.digit_count   = cnt_n;
	assign result.upper_prefix  = upper_n;
	assign result.overflow      = ovf_n;

	// Scan state advances only on an accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hls_pkg::PH_IDLE;
			acc_q   <= '0;
			cnt_q   <= '0;
			upper_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
			upper_q <= upper_n;
			ovf_q   <= ovf_n;
		end
	end

endmodule

@@ design/hls_out_queue.sv @@
// Two-entry result queue that decouples the scanner from a stalling receiver.
// Depends on hls_pkg for the result type.
`timescale 1ns / 1ps

module hls_out_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  hls_pkg::hls_result_t push_data,
	output logic                 has_room,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output hls_pkg::hls_result_t pop_data
);

	hls_pkg::hls_result_t slot_q [2];
	logic                 wr_ptr_q, rd_ptr_q;
	logic [1:0]           count_q;
	logic                 pop;

	assign has_room  = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = slot_q[rd_ptr_q];

	// Entry storage; no reset needed for payload.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/hls_checker.sv @@
// Port-level checks for the hex literal scanner, attached by bind.
// Depends on hls_pkg and on the ports of hex_literal_scanner.
`timescale 1ns / 1ps

module hls_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [hls_pkg::OUT_WIDTH-1:0]   literal_value,
	input logic [hls_pkg::COUNT_WIDTH-1:0] digit_count,
	input logic                            overflow
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A new result only follows an accepted byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without an accepted byte");

	// A literal with no digits has value zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (digit_count == '0) |-> (literal_value == '0))
		else $error("bare prefix with nonzero value");

	// Overflow needs more digits than the value holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |->
			(digit_count >= hls_pkg::COUNT_WIDTH'(hls_pkg::VALUE_WIDTH / 4 + 1)))
		else $error("overflow with too few digits");

endmodule

bind hex_literal_scanner hls_checker u_hls_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.literal_value (out_ch.literal_value),
	.digit_count   (out_ch.digit_count),
	.overflow      (out_ch.overflow)
);

@@ verif/tb_top.sv @@
// Self-checking testbench for hex_literal_scanner: byte stream in, literal results out.
// Depends on hls_pkg and the hls_in_if / hls_out_if channel interfaces from design/.
// A scoreboard class predicts each literal from the accepted bytes and checks the results.
`timescale 1ns / 1ps

module tb_top;

	// Predicts literals from accepted bytes and checks them against the result items.
	class literal_scoreboard;
		logic [1:0]           phase;
		logic [63:0]          acc;
		logic [63:0]          value_mask;
		logic [7:0]           ndig;
		bit                   upper;
		bit                   ovf_flag;
		hls_pkg::hls_result_t pending_literals[$];
		int unsigned          literals_checked;
		int unsigned          overflows_seen;
		int unsigned          saturated_seen;
		int unsigned          errors;

		function new();
			phase = hls_pkg::PH_IDLE;
			acc = '0;
			ndig = '0;
			upper = 1'b0;
			ovf_flag = 1'b0;
			value_mask = {64{1'b1}} >> (64 - hls_pkg::VALUE_WIDTH);
			literals_checked = 0;
			overflows_seen = 0;
			saturated_seen = 0;
			errors = 0;
		endfunction

		// Nibble value of a hex digit byte, or -1 for any other byte.
		static function int nibble_of(logic [7:0] c);
			if (c >= "0" && c <= "9") begin
				return int'(c - "0");
			end
			if (c >= "A" && c <= "F") begin
				return int'(c - "A") + 10;
			end
			if (c >= "a" && c <= "f") begin
				return int'(c - "a") + 10;
			end
			return -1;
		endfunction

		// Closes the literal in progress and queues its expected result.
		function void finish_literal();
			hls_pkg::hls_result_t r;
			r.literal_value = acc & value_mask;
			r.digit_count = ndig;
			r.upper_prefix = upper;
			r.overflow = ovf_flag;
			pending_literals.push_back(r);
			phase = hls_pkg::PH_IDLE;
		endfunction

		// Advances the scan state by one accepted byte.
		function void note_byte(logic [7:0] c, bit eos);
			int d;
			d = nibble_of(c);
			// Inside the digits: a non-hex byte ends the literal and is dropped.
			if (phase == hls_pkg::PH_DIGITS) begin
				if (d < 0) begin
					finish_literal();
					return;
				end
				if ((acc >> (hls_pkg::VALUE_WIDTH - 4)) != 0) begin
					ovf_flag = 1'b1;
				end
				acc = ((acc << 4) | 64'(d)) & value_mask;
				if (ndig != 8'hFF) begin
					ndig++;
				end
				if (eos) begin
					finish_literal();
				end
				return;
			end
			// A '0' followed by x or X opens a new literal.
			if (phase == hls_pkg::PH_ZERO &&
				(c == hls_pkg::CH_X_LOWER || c == hls_pkg::CH_X_UPPER)) begin
				phase = hls_pkg::PH_DIGITS;
				acc = '0;
				ndig = '0;
				upper = (c == hls_pkg::CH_X_UPPER);
				ovf_flag = 1'b0;
				if (eos) begin
					finish_literal();
				end
				return;
			end
			// Otherwise only a '0' can start a prefix; end of stream clears it.
			phase = (c == hls_pkg::CH_ZERO && !eos) ? hls_pkg::PH_ZERO : hls_pkg::PH_IDLE;
		endfunction

		// Compares one result item with the oldest predicted literal.
		function void check_literal(hls_pkg::hls_result_t got);
			hls_pkg::hls_result_t want;
			if (pending_literals.size() == 0) begin
				$error("unexpected literal: value %h, digits %0d", got.literal_value,
					got.digit_count);
				errors++;
				return;
			end
			want = pending_literals.pop_front();
			if (got.literal_value !== want.literal_value) begin
				$error("literal_value: expected %h, got %h", want.literal_value,
					got.literal_value);
				errors++;
			end
			if (got.digit_count !== want.digit_count) begin
				$error("digit_count: expected %0d, got %0d", want.digit_count, got.digit_count);
				errors++;
			end
			if (got.upper_prefix !== want.upper_prefix) begin
				$error("upper_prefix: expected %b, got %b", want.upper_prefix, got.upper_prefix);
				errors++;
			end
			if (got.overflow !== want.overflow) begin
				$error("overflow: expected %b, got %b", want.overflow, got.overflow);
				errors++;
			end
			literals_checked++;
			if (want.overflow) begin
				overflows_seen++;
			end
			if (want.digit_count == 8'hFF) begin
				saturated_seen++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit no_gaps;
	int unsigned bytes_sent;
	literal_scoreboard sb = new();

	hls_in_if  in_ch();
	hls_out_if out_ch();

	hex_literal_scanner dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#5_000_000;
		$error("timeout: %0d literals still pending", sb.pending_literals.size());
		$display("tb_top: FAIL");
		$finish;
	end

	// Result side: check every accepted item and stall at random.
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			hls_pkg::hls_result_t got;
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.literal_value = out_ch.literal_value;
				got.digit_count = out_ch.digit_count;
				got.upper_prefix = out_ch.upper_prefix;
				got.overflow = out_ch.overflow;
				sb.check_literal(got);
			end
			out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 16);
		end
	end

	// Offers one byte, with random idle cycles ahead of it, and waits for acceptance.
	task automatic send_byte(input logic [7:0] c, input bit eos);
		while (!no_gaps && $urandom_range(0, 99) < 16) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.char_in <= c;
		in_ch.end_of_stream <= eos;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
		sb.note_byte(c, eos);
		bytes_sent++;
	endtask

	task automatic send_text(input string s, input bit eos_last);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], eos_last && (i == s.len() - 1));
		end
	endtask

	// Any byte that is not a hex digit.
	function automatic logic [7:0] pick_non_hex();
		logic [7:0] t;
		do begin
			t = 8'($urandom_range(0, 255));
		end while (literal_scoreboard::nibble_of(t) >= 0);
		return t;
	endfunction

	// Mostly short literals, some long enough to overflow, rarely past 255 digits.
	function automatic int unsigned pick_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 12);
		end
		if (r < 98) begin
			return $urandom_range(13, 24);
		end
		return $urandom_range(250, 300);
	endfunction

	// One well-formed literal with random prefix case, leading zeros and digits.
	task automatic send_literal(input int unsigned ndigits);
		string digit_set;
		bit at_eos;
		digit_set = "0123456789abcdefABCDEF";
		at_eos = ($urandom_range(0, 99) < 15);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) send_byte("0", 1'b0);
		end
		send_byte("0", 1'b0);
		send_byte($urandom_range(0, 1) ? "X" : "x", at_eos && ndigits == 0);
		for (int i = 0; i < ndigits; i++) begin
			send_byte(digit_set[$urandom_range(0, 21)], at_eos && (i == ndigits - 1));
		end
		if (!at_eos) begin
			send_byte(pick_non_hex(), $urandom_range(0, 9) == 0);
		end
	endtask

	// Stimulus: reset, directed cases, then random text.
	initial begin
		int unsigned lit_no;
		lit_no = 0;
		no_gaps = 1'b0;
		bytes_sent = 0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.char_in <= '0;
		in_ch.end_of_stream <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Mixed-case digits, leading zeros, a bare prefix at end of stream, a zero
		// right after the prefix, and a terminator that cannot start a new prefix.
		send_text("0x1F ", 1'b0);
		send_text("00X", 1'b1);
		send_text("0xfFaA9", 1'b1);
		send_text("0x0x", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_text("0xg", 1'b0);
		send_text("0", 1'b1);

		// Random text: mostly literals, with noise bytes and broken prefixes between.
		while (bytes_sent < 1250) begin
			lit_no++;
			no_gaps = (bytes_sent >= 300 && bytes_sent < 700);
			repeat ($urandom_range(0, 4)) begin
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
			end
			if ($urandom_range(0, 9) == 0) begin
				send_byte("0", 1'b0);
				send_byte(pick_non_hex(), $urandom_range(0, 3) == 0);
			end else begin
				send_literal(lit_no == 20 ? 260 : pick_length());
			end
		end
		in_ch.valid <= 1'b0;
		no_gaps = 1'b0;

		// Drain the results, then let the last transfers settle.
		while (sb.pending_literals.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		$display("Scanned %0d bytes, checked %0d literals.", bytes_sent, sb.literals_checked);
		$display("Literals with overflow: %0d, with saturated digit count: %0d.",
			sb.overflows_seen, sb.saturated_seen);
		if (sb.errors == 0 && sb.pending_literals.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
